/* sv/ssr_pkg.sv */
// Package for the stereo Schroeder reverb: constants, types and delay-line tables.
// Used by stereo_schroeder_reverb_top; no other dependencies.
package ssr_pkg;

    localparam int SAMPLE_BITS_DEF        = 24;
    localparam int STORE_BITS_DEF         = 28;
    localparam int GAIN_FRACTION_BITS_DEF = 16;

    localparam int COEF_BITS    = 16;
    localparam int COMB_COEF    = 50463;
    localparam int AP_COEF      = 45875;
    localparam int LEVEL_BITS   = 24;
    localparam int SMOOTH_K     = 69760;
    localparam int COMB_TOTAL   = 14662;
    localparam int AP_TOTAL     = 654;
    localparam int COMB_AW      = 14;
    localparam int AP_AW        = 10;
    localparam int CLEAR_CYCLES = COMB_TOTAL;

    localparam logic [1:0] REG_DRY    = 2'd0;
    localparam logic [1:0] REG_WET    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_MUL,
        S_WR,
        S_APRD,
        S_APMUL1,
        S_APMUL2,
        S_APWR,
        S_MIXA,
        S_MIXB,
        S_MIXC,
        S_OUT
    } t_state;

    function automatic logic [11:0] comb_len(input logic [2:0] k);
        unique case (k)
            3'd0: comb_len = 12'd1426;
            3'd1: comb_len = 12'd1781;
            3'd2: comb_len = 12'd1973;
            3'd3: comb_len = 12'd2098;
            3'd4: comb_len = 12'd1443;
            3'd5: comb_len = 12'd1807;
            3'd6: comb_len = 12'd2003;
            default: comb_len = 12'd2131;
        endcase
    endfunction

    function automatic logic [COMB_AW-1:0] comb_base(input logic [2:0] k);
        unique case (k)
            3'd0: comb_base = 14'd0;
            3'd1: comb_base = 14'd1426;
            3'd2: comb_base = 14'd3207;
            3'd3: comb_base = 14'd5180;
            3'd4: comb_base = 14'd7278;
            3'd5: comb_base = 14'd8721;
            3'd6: comb_base = 14'd10528;
            default: comb_base = 14'd12531;
        endcase
    endfunction

    function automatic logic [7:0] ap_len(input logic [1:0] k);
        unique case (k)
            2'd0: ap_len = 8'd240;
            2'd1: ap_len = 8'd82;
            2'd2: ap_len = 8'd247;
            default: ap_len = 8'd85;
        endcase
    endfunction

    function automatic logic [AP_AW-1:0] ap_base(input logic [1:0] k);
        unique case (k)
            2'd0: ap_base = 10'd0;
            2'd1: ap_base = 10'd240;
            2'd2: ap_base = 10'd322;
            default: ap_base = 10'd569;
        endcase
    endfunction

endpackage

/* sv/stereo_schroeder_reverb_top.sv */
// Top level of the stereo Schroeder reverb: four combs and two allpasses per channel.
// Depends on ssr_pkg for constants, delay-line tables and the state type.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: left_in, right_in; tuser: engaged
//  m_axis    out        tdata: left_out, right_out; tuser: tail_active
//  apb       in         dry_gain @0, wet_gain @8, energy_threshold @16 (64-bit data)
//
// After reset a clearing pass zeroes the delay memories; no word is taken meanwhile.
// An engaged frame runs eight comb read-modify-writes (S_RD, S_MUL, S_WR) and four
// allpass steps (S_APRD, S_APMUL1, S_APMUL2, S_APWR) on one shared 30x18 multiplier,
// then the mix states S_MIXA, S_MIXB, S_MIXC and the output state S_OUT. A bypassed
// frame goes straight from S_IDLE to S_OUT. The next word is taken only once the
// result word has left the output register.
module stereo_schroeder_reverb_top #(
    parameter int SAMPLE_BITS        = ssr_pkg::SAMPLE_BITS_DEF,
    parameter int STORE_BITS         = ssr_pkg::STORE_BITS_DEF,
    parameter int GAIN_FRACTION_BITS = ssr_pkg::GAIN_FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // left_in, right_in, zero fill
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // engaged
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // left_out, right_out, zero fill
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tail_active
    output logic                       m_axis_tuser,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import ssr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TB = STORE_BITS;
    localparam int GB = GAIN_FRACTION_BITS;
    localparam int DW = ((2*SB+7)/8)*8;
    localparam int ESH = 2*(SB-1)-30;
    localparam int AW = TB + 2;

    // Configuration registers.
    logic [GB:0] r_dry_gain, r_wet_gain;
    logic [62:0] r_thresh;
    logic        w_cfg;
    assign pready = 1'b1;
    assign w_cfg  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_gain <= (GB+1)'((64'd46341 << GB) >> 16);
            r_wet_gain <= (GB+1)'((64'd46341 << GB) >> 16);
            r_thresh   <= '0;
        end else if (w_cfg && paddr[2:0] == 3'd0) begin
            unique case (paddr[4:3])
                REG_DRY:    r_dry_gain <= pwdata[GB:0];
                REG_WET:    r_wet_gain <= pwdata[GB:0];
                REG_THRESH: r_thresh   <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_DRY:    prdata = 64'(r_dry_gain);
            REG_WET:    prdata = 64'(r_wet_gain);
            REG_THRESH: prdata = 64'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    // Delay memories.
    logic signed [TB-1:0] comb_mem [COMB_TOTAL];
    logic signed [TB-1:0] ap_mem   [AP_TOTAL];
    logic signed [TB-1:0] r_comb_q, r_ap_q;
    logic [COMB_AW-1:0]   comb_addr;
    logic [AP_AW-1:0]     ap_addr;
    logic                 comb_we, ap_we;
    logic signed [TB-1:0] comb_wd, ap_wd;

    always_ff @(posedge i_clk) begin
        if (comb_we) comb_mem[comb_addr] <= comb_wd;
        r_comb_q <= comb_mem[comb_addr];
    end
    always_ff @(posedge i_clk) begin
        if (ap_we) ap_mem[ap_addr] <= ap_wd;
        r_ap_q <= ap_mem[ap_addr];
    end

    t_state r_state, n_state;
    logic [COMB_AW-1:0] r_clr;
    logic [11:0] r_cpos [8];
    logic [7:0]  r_apos [4];
    logic [2:0]  r_k;
    logic        r_ch;
    logic        r_ap_i;
    logic signed [SB-1:0] r_x [2];
    logic        r_eng;
    logic        r_byp;
    logic signed [AW-1:0] r_sum;
    logic signed [AW-1:0] r_v;
    logic signed [AW-1:0] r_o;
    logic signed [AW-1:0] r_wet [2];
    logic signed [TB-1:0] r_d;
    logic signed [AW+COEF_BITS:0] r_prod;
    logic signed [LEVEL_BITS+1:0] r_dry_lvl, r_wet_lvl;
    logic [63:0] r_energy;
    logic        r_epend;
    logic signed [TB-1:0] r_enew, r_eold;
    logic        r_tail;
    logic signed [SB-1:0] r_yl, r_yr;
    logic        r_ovalid;
    logic        r_otail;
    logic signed [AW+LEVEL_BITS+2:0] r_acc;

    // Shared multiplier.
    logic signed [AW-1:0]   mul_a;
    logic signed [COEF_BITS+1:0] mul_b;
    logic signed [AW+COEF_BITS:0] mul_p;
    assign mul_p = (AW+COEF_BITS+1)'(mul_a * mul_b);

    function automatic logic signed [AW-1:0] rnd16(input logic signed [AW+COEF_BITS:0] p);
        logic signed [AW+COEF_BITS:0] t;
        t = p + (AW+COEF_BITS+1)'(1 <<< (COEF_BITS-1));
        rnd16 = AW'(t >>> COEF_BITS);
    endfunction

    function automatic logic signed [TB-1:0] sat_store(input logic signed [AW+1:0] v);
        logic signed [AW+1:0] hi, lo;
        hi = (AW+2)'((64'sd1 <<< (TB-1)) - 1);
        lo = -hi - 1;
        if (v > hi) sat_store = TB'(hi);
        else if (v < lo) sat_store = TB'(lo);
        else sat_store = TB'(v);
    endfunction

    function automatic logic [63:0] energy_of(input logic signed [TB-1:0] v);
        logic [TB-1:0] m;
        logic [2*TB-1:0] sq;
        m  = v[TB-1] ? TB'(-v) : TB'(v);
        sq = m * m;
        energy_of = 64'(sq >> ESH);
    endfunction

    logic [2:0] cidx;
    logic [1:0] aidx;
    logic [11:0] cpos;
    logic [7:0]  apos;
    assign cidx = r_k;
    assign aidx = {r_ch, r_ap_i};
    assign cpos = (r_cpos[cidx] >= comb_len(cidx)) ? 12'd0 : r_cpos[cidx];
    assign apos = (r_apos[aidx] >= ap_len(aidx)) ? 8'd0 : r_apos[aidx];

    logic signed [AW-1:0] comb_new;
    logic signed [AW-1:0] ap_new;
    logic signed [AW-1:0] feed;
    assign feed     = r_eng ? AW'(r_x[r_ch]) : '0;
    assign comb_new = feed + rnd16(r_prod);
    assign ap_new   = r_v + rnd16(r_prod);

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == COMB_AW'(COMB_TOTAL-1)) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = (!s_axis_tuser && !r_tail) ? S_OUT : S_RD;
            S_RD:     n_state = S_MUL;
            S_MUL:    n_state = S_WR;
            S_WR:     n_state = (r_k[1:0] == 2'd3) ? S_APRD : S_RD;
            S_APRD:   n_state = S_APMUL1;
            S_APMUL1: n_state = S_APMUL2;
            S_APMUL2: n_state = S_APWR;
            S_APWR:   n_state = !r_ap_i ? S_APRD : (r_ch ? S_MIXA : S_RD);
            S_MIXA:   n_state = S_MIXB;
            S_MIXB:   n_state = S_MIXC;
            S_MIXC:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        comb_we   = 1'b0;
        ap_we     = 1'b0;
        comb_addr = comb_base(cidx) + COMB_AW'(cpos);
        ap_addr   = ap_base(aidx) + AP_AW'(apos);
        comb_wd   = sat_store((AW+2)'(comb_new));
        ap_wd     = sat_store((AW+2)'(ap_new));
        unique case (r_state)
            S_CLEAR: begin
                comb_we   = 1'b1;
                comb_addr = r_clr;
                comb_wd   = '0;
                ap_we     = (r_clr < COMB_AW'(AP_TOTAL));
                ap_addr   = AP_AW'(r_clr);
                ap_wd     = '0;
            end
            S_WR:   comb_we = 1'b1;
            S_APWR: ap_we = 1'b1;
            default: ;
        endcase
    end

    // Multiplier operands.
    logic [LEVEL_BITS:0] tdry, twet;
    assign tdry = r_eng ? ((r_dry_gain > (GB+1)'(1 << GB)) ? (LEVEL_BITS+1)'(1 << LEVEL_BITS)
                  : (LEVEL_BITS+1)'(r_dry_gain) << (LEVEL_BITS-GB))
                  : (LEVEL_BITS+1)'(1 << LEVEL_BITS);
    assign twet = (r_wet_gain > (GB+1)'(1 << GB)) ? (LEVEL_BITS+1)'(1 << LEVEL_BITS)
                  : (LEVEL_BITS+1)'(r_wet_gain) << (LEVEL_BITS-GB);

    always_comb begin
        mul_a = AW'(r_comb_q);
        mul_b = (COEF_BITS+2)'(COMB_COEF);
        unique case (r_state)
            S_APMUL1: mul_a = r_v;
            S_APMUL2: mul_a = r_o;
            default: ;
        endcase
        if (r_state == S_APMUL1 || r_state == S_APMUL2) mul_b = (COEF_BITS+2)'(AP_COEF);
    end

    logic signed [AW-1:0] ap_o;
    assign ap_o = AW'(r_ap_q) - rnd16(mul_p);

    function automatic logic signed [LEVEL_BITS+1:0] smooth(
        input logic signed [LEVEL_BITS+1:0] lvl, input logic [LEVEL_BITS:0] tgt);
        logic signed [LEVEL_BITS+2:0] diff;
        logic signed [LEVEL_BITS+22:0] p;
        diff = $signed({2'b00, tgt}) - (LEVEL_BITS+3)'(lvl);
        p = (LEVEL_BITS+23)'(diff * $signed(19'sd69760)) + (LEVEL_BITS+23)'(1 <<< (LEVEL_BITS-1));
        smooth = lvl + (LEVEL_BITS+2)'(p >>> LEVEL_BITS);
    endfunction

    logic signed [AW+LEVEL_BITS+2:0] mixp;
    logic signed [AW+LEVEL_BITS+2:0] rnd_acc;
    logic signed [SB-1:0] ysat;
    always_comb begin
        if (r_state == S_MIXB)
            mixp = (AW+LEVEL_BITS+3)'(r_x[0] * r_dry_lvl) + (AW+LEVEL_BITS+3)'(r_wet[0] * r_wet_lvl);
        else
            mixp = (AW+LEVEL_BITS+3)'(r_x[1] * r_dry_lvl) + (AW+LEVEL_BITS+3)'(r_wet[1] * r_wet_lvl);
        rnd_acc = (r_acc + (AW+LEVEL_BITS+3)'(1 <<< (LEVEL_BITS-1))) >>> LEVEL_BITS;
        if (rnd_acc > (AW+LEVEL_BITS+3)'((1 <<< (SB-1)) - 1)) ysat = {1'b0, {(SB-1){1'b1}}};
        else if (rnd_acc < -(AW+LEVEL_BITS+3)'(1 <<< (SB-1))) ysat = {1'b1, {(SB-1){1'b0}}};
        else ysat = SB'(rnd_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_k       <= '0;
            r_ch      <= 1'b0;
            r_ap_i    <= 1'b0;
            r_dry_lvl <= (LEVEL_BITS+2)'(1 << LEVEL_BITS);
            r_wet_lvl <= '0;
            r_energy  <= '0;
            r_epend   <= 1'b0;
            r_tail    <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < 8; i++) r_cpos[i] <= '0;
            for (int i = 0; i < 4; i++) r_apos[i] <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            r_epend <= (r_state == S_WR) || (r_state == S_APWR);
            r_enew  <= (r_state == S_APWR) ? ap_wd : comb_wd;
            r_eold  <= r_d;
            if (r_epend) r_energy <= r_energy + energy_of(r_enew) - energy_of(r_eold);
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (accept) begin
                    r_x[0] <= s_axis_tdata[SB-1:0];
                    r_x[1] <= s_axis_tdata[2*SB-1:SB];
                    r_eng  <= s_axis_tuser;
                    r_byp  <= !s_axis_tuser && !r_tail;
                    r_k    <= '0;
                    r_ch   <= 1'b0;
                    r_ap_i <= 1'b0;
                    r_sum  <= '0;
                    if (!s_axis_tuser && !r_tail) begin
                        r_yl <= s_axis_tdata[SB-1:0];
                        r_yr <= s_axis_tdata[2*SB-1:SB];
                        r_dry_lvl <= (LEVEL_BITS+2)'(1 << LEVEL_BITS);
                        r_wet_lvl <= '0;
                    end
                end
                S_RD: ;
                S_MUL: begin
                    r_d    <= r_comb_q;
                    r_prod <= mul_p;
                end
                S_WR: begin
                    r_cpos[cidx] <= (cpos + 12'd1 >= comb_len(cidx)) ? 12'd0 : cpos + 12'd1;
                    r_k <= r_k + 3'd1;
                    if (r_k[1:0] == 2'd3)
                        r_v <= AW'(((r_sum + AW'(r_d)) + AW'(2)) >>> 2);
                    else
                        r_sum <= r_sum + AW'(r_d);
                end
                S_APRD: ;
                S_APMUL1: begin
                    r_d <= r_ap_q;
                    r_o <= ap_o;
                end
                S_APMUL2: r_prod <= mul_p;
                S_APWR: begin
                    r_apos[aidx] <= (apos + 8'd1 >= ap_len(aidx)) ? 8'd0 : apos + 8'd1;
                    r_v <= r_o;
                    r_ap_i <= !r_ap_i;
                    if (r_ap_i) begin
                        r_wet[r_ch] <= r_o;
                        r_ch  <= 1'b1;
                        r_sum <= '0;
                    end
                end
                S_MIXA: begin
                    r_dry_lvl <= smooth(r_dry_lvl, tdry);
                    r_wet_lvl <= smooth(r_wet_lvl, twet);
                end
                S_MIXB: r_acc <= mixp;
                S_MIXC: begin
                    r_yl  <= ysat;
                    r_acc <= mixp;
                    r_tail <= r_energy > {1'b0, r_thresh};
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_otail  <= r_tail;
                    if (!r_byp) r_yr <= ysat;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = DW'({r_yr, r_yl});
    assign m_axis_tuser  = r_otail;

endmodule
